@@ rtl/core/aes128_pkg.sv @@
// ----------------------------------------------------------------------------
// AES-128 package
// Shared widths, register indexes, S-box table and round helper functions.
// ----------------------------------------------------------------------------
`default_nettype none

package aes128_pkg;

   localparam int HalfWidth   = 64;
   localparam int BlockWidth  = 128;
   localparam int NumRounds   = 10;
   localparam int CsrDataWidth = 64;
   localparam int CsrAddrWidth = 4;

   typedef logic [HalfWidth-1:0]  half_type;
   typedef logic [BlockWidth-1:0] block_type;

   typedef enum logic [0:0] {
      REG_KEY_HIGH = 1'b0,
      REG_KEY_LOW  = 1'b1
   } reg_index_type;

   typedef struct packed {
      logic valid;
      logic hold;
   } cell_ctrl_type;

   localparam logic [7:0] SBOX [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   function automatic logic [7:0] xtime(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [7:0] byte_at(input block_type b, input int i);
      return b[BlockWidth-1-8*i -: 8];
   endfunction

   function automatic block_type sub_shift(input block_type s);
      block_type t;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            t[BlockWidth-1-8*(r+4*c) -: 8] = SBOX[byte_at(s, r + 4*((c + r) % 4))];
         end
      end
      return t;
   endfunction

   function automatic block_type mix_columns(input block_type s);
      block_type t;
      logic [7:0] a0, a1, a2, a3;
      for (int c = 0; c < 4; c++) begin
         a0 = byte_at(s, 4*c);
         a1 = byte_at(s, 4*c+1);
         a2 = byte_at(s, 4*c+2);
         a3 = byte_at(s, 4*c+3);
         t[BlockWidth-1-8*(4*c)   -: 8] = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
         t[BlockWidth-1-8*(4*c+1) -: 8] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
         t[BlockWidth-1-8*(4*c+2) -: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
         t[BlockWidth-1-8*(4*c+3) -: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
      end
      return t;
   endfunction

   function automatic block_type next_key(input block_type k, input logic [7:0] rcon);
      logic [31:0] w0, w1, w2, w3, t;
      w0 = k[127:96];
      w1 = k[95:64];
      w2 = k[63:32];
      w3 = k[31:0];
      t = {SBOX[w3[23:16]] ^ rcon, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
      w0 = w0 ^ t;
      w1 = w1 ^ w0;
      w2 = w2 ^ w1;
      w3 = w3 ^ w2;
      return {w0, w1, w2, w3};
   endfunction

endpackage

`default_nettype wire

@@ rtl/core/aes128_stream_if.sv @@
// ----------------------------------------------------------------------------
// AES-128 stream interface
// Valid/ready channel carrying one 128-bit block as two 64-bit halves.
// ----------------------------------------------------------------------------
`default_nettype none

interface aes128_stream_if;
   logic                      valid;
   logic                      ready;
   aes128_pkg::half_type      data_high;
   aes128_pkg::half_type      data_low;

   modport source (output valid, output data_high, output data_low, input ready);
   modport sink   (input valid, input data_high, input data_low, output ready);
endinterface

`default_nettype wire

@@ rtl/core/aes128_round_cell.sv @@
// ----------------------------------------------------------------------------
// AES-128 round cell
// One round of the cipher and one step of the key expansion, registered.
// ----------------------------------------------------------------------------
`default_nettype none

module aes128_round_cell #(
   parameter int RoundIndex = 1
) (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        advance,
   input  wire                        valid_in,
   input  wire aes128_pkg::block_type state_in,
   input  wire aes128_pkg::block_type key_in,
   output logic                       valid_out,
   output aes128_pkg::block_type      state_out,
   output aes128_pkg::block_type      key_out
);
   import aes128_pkg::*;

   localparam logic [7:0] RconValues [10] = '{8'h01, 8'h02, 8'h04, 8'h08, 8'h10,
                                              8'h20, 8'h40, 8'h80, 8'h1b, 8'h36};

   logic      valid_ff;
   block_type state_ff, key_ff, state_in_w, key_in_w, shifted;

   always_comb begin
      key_in_w = next_key(key_in, RconValues[RoundIndex-1]);
      shifted  = sub_shift(state_in);
      if (RoundIndex == NumRounds) begin
         state_in_w = shifted ^ key_in_w;
      end else begin
         state_in_w = mix_columns(shifted) ^ key_in_w;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
      if (advance) begin
         state_ff <= state_in_w;
         key_ff   <= key_in_w;
      end
   end

   assign valid_out = valid_ff;
   assign state_out = state_ff;
   assign key_out   = key_ff;
endmodule

`default_nettype wire

@@ rtl/core/aes128_block_encrypt_unit.sv @@
// ----------------------------------------------------------------------------
// AES-128 block encryption unit
// Ten round cells in a chain, each carrying a block and its round key.
// ----------------------------------------------------------------------------
// A request is captured in the input register with the key added, then passes
// through the ten round cells in order; the result is taken from the last cell.
// Throughput: one request per cycle, set by the ten-cell round chain, while it does not stall.
// The chain stalls as a whole while the result is not taken.
// Reset clears the valid bits and both key registers to zero.
`default_nettype none

module aes128_block_encrypt_unit (
   input  wire                                 clock,
   input  wire                                 reset,
   aes128_stream_if.sink                       req,
   aes128_stream_if.source                     rsp,
   input  wire                                 csr_psel,
   input  wire                                 csr_penable,
   input  wire                                 csr_pwrite,
   input  wire [aes128_pkg::CsrAddrWidth-1:0]  csr_paddr,
   input  wire [aes128_pkg::CsrDataWidth-1:0]  csr_pwdata,
   output logic [aes128_pkg::CsrDataWidth-1:0] csr_prdata,
   output logic                                csr_pready
);
   import aes128_pkg::*;

   half_type  key_high_ff, key_low_ff;
   logic      valid_ff, advance;
   block_type state_ff, key_ff;
   logic      cell_valid [NumRounds+1];
   block_type cell_state [NumRounds+1];
   block_type cell_key   [NumRounds+1];
   logic      csr_write;
   logic      reg_sel;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite;
   assign reg_sel    = csr_paddr[3];

   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff <= '0;
         key_low_ff  <= '0;
      end else if (csr_write && csr_paddr[2:0] == 3'b000) begin
         if (reg_index_type'(reg_sel) == REG_KEY_HIGH) begin
            key_high_ff <= csr_pwdata;
         end else begin
            key_low_ff <= csr_pwdata;
         end
      end
   end

   always_comb begin
      if (reg_index_type'(reg_sel) == REG_KEY_HIGH) begin
         csr_prdata = key_high_ff;
      end else begin
         csr_prdata = key_low_ff;
      end
   end

   assign advance   = !cell_valid[NumRounds] || rsp.ready;
   assign req.ready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= req.valid;
      end
      if (advance) begin
         state_ff <= {req.data_high, req.data_low} ^ {key_high_ff, key_low_ff};
         key_ff   <= {key_high_ff, key_low_ff};
      end
   end

   assign cell_valid[0] = valid_ff;
   assign cell_state[0] = state_ff;
   assign cell_key[0]   = key_ff;

   for (genvar g = 1; g <= NumRounds; g++) begin : g_round
      aes128_round_cell #(.RoundIndex(g)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .valid_in (cell_valid[g-1]),
         .state_in (cell_state[g-1]),
         .key_in   (cell_key[g-1]),
         .valid_out(cell_valid[g]),
         .state_out(cell_state[g]),
         .key_out  (cell_key[g])
      );
   end

   assign rsp.valid     = cell_valid[NumRounds];
   assign rsp.data_high = cell_state[NumRounds][BlockWidth-1:HalfWidth];
   assign rsp.data_low  = cell_state[NumRounds][HalfWidth-1:0];
endmodule

`default_nettype wire
